// ===== hdl/i2r_pkg.sv =====
// shared types, codes and constant tables for the integer to roman numeral converter
// microcode word layout, control/status structs between sequencer and datapath
// no dependencies
package i2r_pkg;

   // accepted value range
   localparam int unsigned MIN_VALUE = 1;
   localparam int unsigned MAX_VALUE = 3999;

   typedef logic [11:0] value_type;
   typedef logic [13:0] wide_type;
   typedef logic [7:0]  char_type;
   typedef logic [3:0]  digit_type;
   typedef logic [1:0]  place_type;
   typedef logic [5:0]  step_type;
   typedef logic [2:0]  op_type;
   typedef logic [1:0]  sym_type;

   // micro-operations
   localparam op_type OP_WAIT  = 3'd0;
   localparam op_type OP_SPLIT = 3'd1;
   localparam op_type OP_EMIT  = 3'd2;
   localparam op_type OP_SKIP  = 3'd3;
   localparam op_type OP_ERR   = 3'd4;

   // symbol roles within one decimal place
   localparam sym_type SYM_ONE  = 2'd0;
   localparam sym_type SYM_FIVE = 2'd1;
   localparam sym_type SYM_TEN  = 2'd2;

   // fixed program addresses, digit patterns start at STEP_PAT + 4 * digit
   localparam step_type STEP_WAIT  = 6'd0;
   localparam step_type STEP_SPLIT = 6'd1;
   localparam step_type STEP_ERR   = 6'd2;
   localparam step_type STEP_PAT   = 6'd8;

   localparam place_type PLACE_TOP = 2'd3;

   localparam char_type CH_M = 8'h4D;
   localparam char_type CH_D = 8'h44;
   localparam char_type CH_C = 8'h43;
   localparam char_type CH_L = 8'h4C;
   localparam char_type CH_X = 8'h58;
   localparam char_type CH_V = 8'h56;
   localparam char_type CH_I = 8'h49;
   localparam char_type CASE_BIT = 8'h20;

   typedef struct packed {
      op_type  op;
      sym_type sym;
      logic    fin;
   } ucode_type;

   localparam ucode_type UC_WAIT   = '{op: OP_WAIT,  sym: SYM_ONE,  fin: 1'b0};
   localparam ucode_type UC_SPLIT  = '{op: OP_SPLIT, sym: SYM_ONE,  fin: 1'b0};
   localparam ucode_type UC_ERR    = '{op: OP_ERR,   sym: SYM_ONE,  fin: 1'b1};
   localparam ucode_type UC_SKIP   = '{op: OP_SKIP,  sym: SYM_ONE,  fin: 1'b1};
   localparam ucode_type UC_ONE    = '{op: OP_EMIT,  sym: SYM_ONE,  fin: 1'b0};
   localparam ucode_type UC_ONE_F  = '{op: OP_EMIT,  sym: SYM_ONE,  fin: 1'b1};
   localparam ucode_type UC_FIVE   = '{op: OP_EMIT,  sym: SYM_FIVE, fin: 1'b0};
   localparam ucode_type UC_FIVE_F = '{op: OP_EMIT,  sym: SYM_FIVE, fin: 1'b1};
   localparam ucode_type UC_TEN_F  = '{op: OP_EMIT,  sym: SYM_TEN,  fin: 1'b1};

   typedef struct packed {
      logic    load;
      logic    split;
      logic    emit;
      logic    emit_err;
      logic    next_place;
      sym_type sym;
      logic    fin;
   } ctl_type;

   typedef struct packed {
      logic      out_free;
      logic      done;
      logic      in_range;
      digit_type digit;
   } sts_type;

   function automatic logic value_in_range(input value_type v);
      return (32'(v) >= MIN_VALUE) && (32'(v) <= MAX_VALUE);
   endfunction

   // k times the weight of the given decimal place
   function automatic wide_type threshold(input place_type p, input digit_type k);
      wide_type scale;
      unique case (p)
         2'd3:    scale = 14'd1000;
         2'd2:    scale = 14'd100;
         2'd1:    scale = 14'd10;
         default: scale = 14'd1;
      endcase
      return 14'(32'(k) * 32'(scale));
   endfunction

   function automatic char_type letter(input place_type p, input sym_type s);
      char_type ch;
      unique case ({p, s})
         {2'd0, SYM_ONE}:  ch = CH_I;
         {2'd0, SYM_FIVE}: ch = CH_V;
         {2'd0, SYM_TEN}:  ch = CH_X;
         {2'd1, SYM_ONE}:  ch = CH_X;
         {2'd1, SYM_FIVE}: ch = CH_L;
         {2'd1, SYM_TEN}:  ch = CH_C;
         {2'd2, SYM_ONE}:  ch = CH_C;
         {2'd2, SYM_FIVE}: ch = CH_D;
         {2'd2, SYM_TEN}:  ch = CH_M;
         default:          ch = CH_M;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/i2r_req_if.sv =====
// request channel: value and case choice with valid/ready handshake
// depends on i2r_pkg
interface i2r_req_if import i2r_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;
   logic      lower_case;

   modport source(output valid, value, lower_case, input ready);
   modport sink(input valid, value, lower_case, output ready);
endinterface

// ===== hdl/i2r_rsp_if.sv =====
// result channel: one numeral character per result beat, with last and error flags
// depends on i2r_pkg
interface i2r_rsp_if import i2r_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;
   logic     range_error;

   modport source(output valid, character, last, range_error, input ready);
   modport sink(input valid, character, last, range_error, output ready);
endinterface

// ===== hdl/integer_to_roman_numeral.sv =====
// integer to roman numeral converter, one ascii letter per result beat
// a request is accepted in the wait step, then each decimal place, from the thousands down,
// takes a split step plus one emit step per letter (a skip step for a zero digit), stopping
// once the remainder is zero; an out-of-range value goes to the error step, which gives a single
// result; emit and error steps wait for a free output register, so output stalls hold them
// synchronous active-high reset returns the sequencer to idle and drops the output valid
module integer_to_roman_numeral import i2r_pkg::*; (
   input logic       clock,
   input logic       reset,
   i2r_req_if.sink   req_chan,
   i2r_rsp_if.source rsp_chan
);

   ctl_type  ctl;
   sts_type  sts;
   step_type step;

   i2r_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .ctl       (ctl),
      .step      (step)
   );

   i2r_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_value       (req_chan.value),
      .req_lower_case  (req_chan.lower_case),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_character   (rsp_chan.character),
      .rsp_last        (rsp_chan.last),
      .rsp_range_error (rsp_chan.range_error)
   );

   // an out-of-range request goes straight to the error step
   a_err_jump: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !sts.in_range) |=> (step == STEP_ERR))
      else $error("out-of-range request did not reach the error step");

   // error results are a single zero beat marked last
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.range_error) |->
      (rsp_chan.last && (rsp_chan.character == '0)))
      else $error("malformed error result");

   // letters are always in the upper or lower case ascii letter blocks
   a_letter: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.range_error) |->
      ((rsp_chan.character[7:5] == 3'b010) || (rsp_chan.character[7:5] == 3'b011)))
      else $error("result character is not a letter");

   // no emission can happen while the sequencer waits for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (step == STEP_WAIT) |-> !(ctl.emit || ctl.emit_err || ctl.split))
      else $error("datapath activity while idle");

endmodule

// ===== hdl/i2r_ucode_rom.sv =====
// microprogram store: control steps and the per-digit letter patterns
// depends on i2r_pkg
module i2r_ucode_rom import i2r_pkg::*; (
   input  step_type  addr,
   output ucode_type word
);

   always_comb begin
      case (addr)
         STEP_WAIT:  word = UC_WAIT;
         STEP_SPLIT: word = UC_SPLIT;
         STEP_ERR:   word = UC_ERR;
         // digit 0: nothing to emit
         6'd8:  word = UC_SKIP;
         // digit 1
         6'd12: word = UC_ONE_F;
         // digit 2
         6'd16: word = UC_ONE;
         6'd17: word = UC_ONE_F;
         // digit 3
         6'd20: word = UC_ONE;
         6'd21: word = UC_ONE;
         6'd22: word = UC_ONE_F;
         // digit 4
         6'd24: word = UC_ONE;
         6'd25: word = UC_FIVE_F;
         // digit 5
         6'd28: word = UC_FIVE_F;
         // digit 6
         6'd32: word = UC_FIVE;
         6'd33: word = UC_ONE_F;
         // digit 7
         6'd36: word = UC_FIVE;
         6'd37: word = UC_ONE;
         6'd38: word = UC_ONE_F;
         // digit 8
         6'd40: word = UC_FIVE;
         6'd41: word = UC_ONE;
         6'd42: word = UC_ONE;
         6'd43: word = UC_ONE_F;
         // digit 9
         6'd44: word = UC_ONE;
         6'd45: word = UC_TEN_F;
         default: word = UC_WAIT;
      endcase
   end

endmodule

// ===== hdl/i2r_seq.sv =====
// microcode sequencer: step counter, program store and conditional jumps
// depends on i2r_pkg and i2r_ucode_rom
module i2r_seq import i2r_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  sts_type  sts,
   output ctl_type  ctl,
   output step_type step
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;

   i2r_ucode_rom u_rom (
      .addr (step_ff),
      .word (word)
   );

   always_comb begin
      ctl       = '0;
      ctl.sym   = word.sym;
      ctl.fin   = word.fin;
      req_ready = 1'b0;
      step_in   = step_ff;
      unique case (word.op)
         OP_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               step_in  = sts.in_range ? STEP_SPLIT : STEP_ERR;
            end
         end
         OP_SPLIT: begin
            ctl.split = 1'b1;
            // jump into the pattern of the digit just taken off
            step_in   = STEP_PAT + {sts.digit, 2'b00};
         end
         OP_EMIT: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               if (word.fin) begin
                  ctl.next_place = 1'b1;
                  step_in        = sts.done ? STEP_WAIT : STEP_SPLIT;
               end else begin
                  step_in = step_ff + 6'd1;
               end
            end
         end
         OP_SKIP: begin
            ctl.next_place = 1'b1;
            step_in        = sts.done ? STEP_WAIT : STEP_SPLIT;
         end
         OP_ERR: begin
            if (sts.out_free) begin
               ctl.emit_err = 1'b1;
               step_in      = STEP_WAIT;
            end
         end
         default: step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

// ===== hdl/i2r_dpath.sv =====
// datapath: remainder and place registers, digit split unit, letter lookup, output register
// depends on i2r_pkg
module i2r_dpath import i2r_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  ctl_type   ctl,
   output sts_type   sts,
   input  value_type req_value,
   input  logic      req_lower_case,
   input  logic      rsp_ready,
   output logic      rsp_valid,
   output char_type  rsp_character,
   output logic      rsp_last,
   output logic      rsp_range_error
);

   value_type rem_ff, rem_in;
   place_type place_ff, place_in;
   logic      lower_ff, lower_in;
   logic      valid_ff, valid_in;
   char_type  char_ff, char_in;
   logic      last_ff, last_in;
   logic      err_ff, err_in;

   digit_type split_digit;
   wide_type  split_sub;
   logic      out_free;
   logic      req_in_range;

   // largest k with k * weight not above the remainder
   always_comb begin
      split_digit = '0;
      split_sub   = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, rem_ff} >= threshold(place_ff, 4'(k))) begin
            split_digit = 4'(k);
            split_sub   = threshold(place_ff, 4'(k));
         end
      end
   end

   assign req_in_range = value_in_range(req_value);
   assign out_free     = !valid_ff || rsp_ready;

   assign sts.out_free = out_free;
   assign sts.done     = (rem_ff == '0);
   assign sts.in_range = req_in_range;
   assign sts.digit    = split_digit;

   always_comb begin
      rem_in   = rem_ff;
      place_in = place_ff;
      lower_in = lower_ff;
      if (ctl.load) begin
         rem_in   = req_in_range ? req_value : '0;
         place_in = PLACE_TOP;
         lower_in = req_lower_case;
      end else begin
         if (ctl.split) begin
            rem_in = rem_ff - split_sub[11:0];
         end
         if (ctl.next_place) begin
            place_in = place_ff - 2'd1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (ctl.emit) begin
         valid_in = 1'b1;
         char_in  = letter(place_ff, ctl.sym) | (lower_ff ? CASE_BIT : '0);
         // final letter once no lower place has anything left
         last_in  = ctl.fin && (rem_ff == '0);
         err_in   = 1'b0;
      end else if (ctl.emit_err) begin
         valid_in = 1'b1;
         char_in  = '0;
         last_in  = 1'b1;
         err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      place_ff <= place_in;
      lower_ff <= lower_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_character   = char_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

endmodule
